// ===== src/bffa_pkg.sv =====
// Shared types and constants of the bitmap first-fit allocator.
// No dependencies; the interfaces and the top level import it.
package bffa_pkg;

   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned INDEX_BITS  = 12;
   localparam int unsigned LIMIT_BITS  = 13;
   localparam int unsigned INDEX_SPAN  = 4096;

   localparam logic       CMD_ALLOCATE = 1'b0;
   localparam logic       CMD_RELEASE  = 1'b1;

   localparam logic [1:0] STATUS_GRANTED  = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_RELEASED = 2'd2;
   localparam logic [1:0] STATUS_RANGE    = 2'd3;

   localparam logic [LIMIT_BITS-1:0] ACTIVE_RESET = 13'd4096;

   // register index on the configuration port
   localparam logic REG_ACTIVE_UNITS = 1'b0;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_RMW,
      S_DONE
   } state_type;

endpackage

// ===== src/bffa_req_if.sv =====
// Request channel: valid/ready handshake carrying command and unit_index.
// Depends on bffa_pkg for field widths.
interface bffa_req_if;
   import bffa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [INDEX_BITS-1:0] unit_index;

   modport source (output valid, output command, output unit_index, input ready);
   modport sink   (input valid, input command, input unit_index, output ready);
endinterface

// ===== src/bffa_rsp_if.sv =====
// Result channel: valid/ready handshake carrying status and granted_index.
// Depends on bffa_pkg for field widths.
interface bffa_rsp_if;
   import bffa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            status;
   logic [INDEX_BITS-1:0] granted_index;

   modport source (output valid, output status, output granted_index, input ready);
   modport sink   (input valid, input status, input granted_index, output ready);
endinterface

// ===== src/bitmap_first_fit_allocator.sv =====
// Top level of the bitmap first-fit allocator: FSM, bitmap memory, APB register.
// Depends on bffa_pkg, bffa_req_if and bffa_rsp_if.
//
// Usage:
//   req_bus (sink) takes one beat per request: command 0 allocates the lowest
//   free unit below the active limit, command 1 releases unit_index.
//   rsp_bus (source) returns exactly one beat per request with status and
//   granted_index (zero unless status is granted).
//   csr_* is an APB-style port with one register, active_units, at byte 0.
//   The limit is min(active_units, UNIT_CAPACITY, 4096).
// Timing:
//   One request in flight. An allocate scans from word 0 up to a free bit or
//   the limit, a release rewrites one word, an early range or full answer
//   skips both; ready returns with the result. One word read per cycle.
// Reset:
//   A clearing pass walks the bitmap memory one word per cycle over all
//   ceil(min(UNIT_CAPACITY,4096)/32) words (128 by default); no request is
//   taken until it ends. Register writes are taken throughout.
// Stall:
//   A pending result holds in the output register; the next request is still
//   accepted and runs up to its own result, which waits until the slot frees.
module bitmap_first_fit_allocator #(
   parameter int unsigned UNIT_CAPACITY = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   bffa_req_if.sink                    req_bus,
   bffa_rsp_if.source                  rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import bffa_pkg::*;

   // units beyond the 12-bit index span are never reached
   localparam int unsigned CAP   = (UNIT_CAPACITY < INDEX_SPAN) ? UNIT_CAPACITY : INDEX_SPAN;
   localparam int unsigned WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [LIMIT_BITS-1:0] CAP_LIMIT = LIMIT_BITS'(CAP);
   localparam logic [WAW-1:0]        LAST_WORD = WAW'(WORDS - 1);

   // bitmap memory
   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WAW-1:0]       rd_addr;
   logic [WAW-1:0]       wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 wr_en;

   // control and payload registers
   state_type             state_ff, state_in;
   logic [WAW-1:0]        clr_ff, clr_in;
   logic [WAW-1:0]        wptr_ff, wptr_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic [LIMIT_BITS-1:0] lim_ff, lim_in;
   logic [LIMIT_BITS-1:0] active_ff, active_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [INDEX_BITS-1:0] res_index_ff, res_index_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;

   // scan datapath
   logic [LIMIT_BITS-1:0] limit_now;
   logic [LIMIT_BITS-1:0] word_base;
   logic [LIMIT_BITS-1:0] remain;
   logic [WORD_BITS-1:0]  live_mask;
   logic [WORD_BITS-1:0]  busy;
   logic                  hit;
   logic                  last_word;
   logic [4:0]            free_bit;
   logic                  req_take;
   logic                  rsp_load;
   logic                  csr_write;

   assign limit_now = (active_ff > CAP_LIMIT) ? CAP_LIMIT : active_ff;
   assign req_take  = req_bus.valid && req_bus.ready;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // take requests only while idle
   assign req_bus.ready = (state_ff == S_IDLE);

   // word under scan: bits at or past the limit count as taken
   assign word_base = LIMIT_BITS'({wptr_ff, 5'b00000});
   assign remain    = lim_ff - word_base;
   assign live_mask = (remain >= LIMIT_BITS'(WORD_BITS)) ? '1
                    : ((WORD_BITS'(1) << remain[4:0]) - WORD_BITS'(1));
   assign busy      = rd_data_ff | ~live_mask;
   assign hit       = ~&busy;
   assign last_word = (remain <= LIMIT_BITS'(WORD_BITS));

   always_comb begin
      free_bit = 5'd0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!busy[b]) begin
            free_bit = 5'(b);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LAST_WORD) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_bus.command == CMD_ALLOCATE) begin
                  state_in = (limit_now == '0) ? S_DONE : S_SCAN;
               end else begin
                  state_in = ({1'b0, req_bus.unit_index} >= limit_now) ? S_DONE : S_RMW;
               end
            end
         end
         S_SCAN: begin
            if (hit || last_word) state_in = S_DONE;
         end
         S_RMW: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // outputs and datapath of each state
   always_comb begin
      clr_in        = clr_ff;
      wptr_in       = wptr_ff;
      idx_in        = idx_ff;
      lim_in        = lim_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rd_addr       = wptr_ff;
      wr_en         = 1'b0;
      wr_addr       = wptr_ff;
      wr_data       = rd_data_ff;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + WAW'(1);
         end
         S_IDLE: begin
            if (req_take) begin
               idx_in       = req_bus.unit_index;
               lim_in       = limit_now;
               res_index_in = '0;
               if (req_bus.command == CMD_ALLOCATE) begin
                  res_status_in = STATUS_FULL;
                  wptr_in       = '0;
                  rd_addr       = '0;
               end else begin
                  res_status_in = ({1'b0, req_bus.unit_index} >= limit_now)
                                ? STATUS_RANGE : STATUS_RELEASED;
                  rd_addr       = WAW'(req_bus.unit_index[INDEX_BITS-1:5]);
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               wr_en         = 1'b1;
               wr_data       = rd_data_ff | (WORD_BITS'(1) << free_bit);
               res_status_in = STATUS_GRANTED;
               res_index_in  = INDEX_BITS'(word_base + LIMIT_BITS'(free_bit));
            end else if (!last_word) begin
               // advance to the next word
               wptr_in = wptr_ff + WAW'(1);
               rd_addr = wptr_ff + WAW'(1);
            end
         end
         S_RMW: begin
            wr_en   = 1'b1;
            wr_addr = WAW'(idx_ff[INDEX_BITS-1:5]);
            wr_data = rd_data_ff & ~(WORD_BITS'(1) << idx_ff[4:0]);
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_index_in  = res_index_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.granted_index = rsp_index_ff;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign active_in  = (csr_write && csr_paddr[2] == REG_ACTIVE_UNITS)
                     ? csr_pwdata[LIMIT_BITS-1:0] : active_ff;
   assign csr_prdata = (csr_paddr[2] == REG_ACTIVE_UNITS)
                     ? {{(32-LIMIT_BITS){1'b0}}, active_ff} : '0;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= ACTIVE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      wptr_ff       <= wptr_in;
      idx_ff        <= idx_in;
      lim_ff        <= lim_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   // checks
   a_index_zero_unless_granted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_GRANTED |-> rsp_index_ff == '0)
      else $error("granted_index nonzero on a non-grant result");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> word_base < lim_ff)
      else $error("scan pointer passed the limit");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR && state_in == S_IDLE |-> clr_ff == LAST_WORD)
      else $error("clearing pass ended early");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result loaded outside the done state");

endmodule

// ===== verif/bitmap_first_fit_allocator_test.sv =====
// Testbench for the bitmap first-fit allocator: directed and random allocate and
// release beats, checked against a bitmap predictor held in a small scoreboard.
// Depends on bffa_pkg, bffa_req_if, bffa_rsp_if and bitmap_first_fit_allocator.
module bitmap_first_fit_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bffa_pkg::*;

   localparam int unsigned WORD_COUNT       = INDEX_SPAN / WORD_BITS;
   // second register slot: nothing is mapped there, so writes must be dropped
   localparam logic        REG_SPARE        = 1'b1;
   localparam logic [2:0]  ADDR_ACTIVE      = {REG_ACTIVE_UNITS, 2'b00};
   localparam logic [2:0]  ADDR_SPARE       = {REG_SPARE, 2'b00};
   localparam int unsigned TARGET_ITEMS     = 850;
   localparam int unsigned LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [1:0]            status;
      logic [INDEX_BITS-1:0] granted_index;
   } alloc_result_type;

   // Bitmap predictor plus the queue of results it still owes.
   class alloc_scoreboard;
      logic [WORD_BITS-1:0]  usage_words [WORD_COUNT];
      logic [LIMIT_BITS-1:0] active_units;
      alloc_result_type      owed_q [$];
      int unsigned           mismatches;
      int unsigned           granted_count;
      int unsigned           full_count;
      int unsigned           released_count;
      int unsigned           range_count;

      function new();
         foreach (usage_words[w]) usage_words[w] = '0;
         active_units   = ACTIVE_RESET;
         mismatches     = 0;
         granted_count  = 0;
         full_count     = 0;
         released_count = 0;
         range_count    = 0;
      endfunction

      function void write_register(logic [2:0] addr, logic [31:0] value);
         if (addr == ADDR_ACTIVE) active_units = value[LIMIT_BITS-1:0];
      endfunction

      function int unsigned limit();
         return (active_units > INDEX_SPAN) ? INDEX_SPAN : int'(active_units);
      endfunction

      function void note_request(logic cmd, logic [INDEX_BITS-1:0] idx);
         alloc_result_type r;
         int unsigned      lim;
         lim             = limit();
         r.status        = STATUS_FULL;
         r.granted_index = '0;
         if (cmd == CMD_ALLOCATE) begin
            for (int unsigned u = 0; u < lim; u++) begin
               if (!usage_words[u / WORD_BITS][u % WORD_BITS]) begin
                  usage_words[u / WORD_BITS][u % WORD_BITS] = 1'b1;
                  r.status        = STATUS_GRANTED;
                  r.granted_index = INDEX_BITS'(u);
                  break;
               end
            end
         end else if (idx >= lim) begin
            r.status = STATUS_RANGE;
         end else begin
            usage_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
            r.status = STATUS_RELEASED;
         end
         case (r.status)
            STATUS_GRANTED:  granted_count++;
            STATUS_FULL:     full_count++;
            STATUS_RELEASED: released_count++;
            default:         range_count++;
         endcase
         owed_q.push_back(r);
      endfunction

      function void check_result(logic [1:0] status, logic [INDEX_BITS-1:0] granted_index);
         alloc_result_type want;
         if (owed_q.size() == 0) begin
            mismatches++;
            $display("%0t: expected no result beat, got status %0d granted_index %0d",
                     $time, status, granted_index);
            return;
         end
         want = owed_q.pop_front();
         if (status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
         end
         if (granted_index !== want.granted_index) begin
            mismatches++;
            $display("%0t: granted_index expected %0d, got %0d",
                     $time, want.granted_index, granted_index);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shared pacing controls: idle_on enables random gaps on both sides,
   // hold_results asks the result side for one long hold-off
   bit          idle_on;
   bit          hold_results;
   int unsigned items_sent;
   int unsigned settings_used;

   alloc_scoreboard sb = new();

   bffa_req_if req_bus ();
   bffa_rsp_if rsp_bus ();

   bitmap_first_fit_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample both channels on the edge; everything around them changes by
   // nonblocking assignment, so the values seen here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.command, req_bus.unit_index);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.status, rsp_bus.granted_index);
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idle_on) return 0;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Offer one request beat and hold it until the block takes it. Valid is
   // only lowered when a gap comes first, so back-to-back beats keep it high.
   task automatic issue_request(input logic cmd, input logic [INDEX_BITS-1:0] idx);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.unit_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // Setup cycle, then access cycle; the register takes the value at the edge
   // that closes the access, so update the predictor there.
   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_register(addr, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_ACTIVE) settings_used++;
   endtask

   // Drop valid and wait for every owed result. Step one edge first so the
   // monitor has logged a beat taken on the current edge.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off on request so the
   // output register fills, the next request parks behind it and the input stalls.
   initial begin : result_ready_driver
      int unsigned stall;
      int unsigned run;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_results) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end
         stall = pick_gap();
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         run = $urandom_range(8, 1);
         repeat (run) @(posedge clock);
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned count;
      int unsigned lim;
      int unsigned roll;
      logic [31:0] setting;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_ALLOCATE;
      req_bus.unit_index = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      idle_on            = 1'b0;
      hold_results       = 1'b0;
      items_sent         = 0;
      settings_used      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset limit of 4096. Requests wait out the clearing pass on ready.
      issue_request(CMD_ALLOCATE, '0);          // unit 0
      issue_request(CMD_ALLOCATE, 12'hFFF);     // unit 1, index is ignored
      issue_request(CMD_RELEASE, 12'd0);
      issue_request(CMD_ALLOCATE, '0);          // lowest free again: unit 0
      issue_request(CMD_RELEASE, 12'hFFF);      // top unit, already free
      issue_request(CMD_RELEASE, 12'd2);        // free unit stays free

      // Limit of 2 with both units held: full, and release at 2 is out of range.
      wait_idle();
      write_csr(ADDR_ACTIVE, 32'd2);
      issue_request(CMD_ALLOCATE, '0);
      issue_request(CMD_RELEASE, 12'd2);
      issue_request(CMD_RELEASE, 12'hFFF);

      // Zero active units: allocate is full, every release out of range.
      wait_idle();
      write_csr(ADDR_ACTIVE, 32'd0);
      issue_request(CMD_ALLOCATE, '0);
      issue_request(CMD_RELEASE, 12'd0);

      // All ones on the bus: the field keeps 8191, which caps to 4096.
      wait_idle();
      write_csr(ADDR_ACTIVE, 32'hFFFF_FFFF);
      issue_request(CMD_ALLOCATE, '0);
      issue_request(CMD_RELEASE, 12'hFFF);

      wait_idle();
      write_csr(ADDR_ACTIVE, 32'd4097);
      issue_request(CMD_ALLOCATE, '0);

      // Write to the unmapped slot: the limit must not move.
      wait_idle();
      write_csr(ADDR_SPARE, 32'd1);
      issue_request(CMD_ALLOCATE, '0);

      // One unit: the bits above the limit stay set and show up again later.
      wait_idle();
      write_csr(ADDR_ACTIVE, 32'd1);
      issue_request(CMD_ALLOCATE, '0);
      issue_request(CMD_RELEASE, 12'd0);
      issue_request(CMD_ALLOCATE, '0);
      issue_request(CMD_RELEASE, 12'd1);

      wait_idle();
      write_csr(ADDR_ACTIVE, 32'd4096);
      issue_request(CMD_ALLOCATE, '0);

      // Random phases: a new limit per phase, then a burst of requests that
      // leans on allocate so small limits run full and release traffic churns
      // the low words of the map.
      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         wait_idle();
         case ($urandom_range(10))
            0:       setting = 32'd1;
            1:       setting = 32'd31;
            2:       setting = 32'd32;
            3:       setting = 32'd33;
            4:       setting = 32'd4096;
            5:       setting = 32'd8191;
            6:       setting = 32'd0;
            7:       setting = $urandom();
            default: setting = $urandom_range(300, 2);
         endcase
         write_csr(ADDR_ACTIVE, setting);
         lim   = sb.limit();
         count = $urandom_range(70, 20);
         // leave some phases free of gaps on both sides
         idle_on = ($urandom_range(3) != 0);
         if (phase == 3) begin
            idle_on      = 1'b1;
            hold_results = 1'b1;
         end
         repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 55)
               issue_request(CMD_ALLOCATE, INDEX_BITS'($urandom()));
            else if (roll < 85 && lim != 0)
               issue_request(CMD_RELEASE, INDEX_BITS'($urandom_range(lim - 1)));
            else
               issue_request(CMD_RELEASE, INDEX_BITS'($urandom()));
         end
         phase++;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Run covered %0d requests under %0d limit settings.", items_sent, settings_used);
      $display("Results: %0d granted, %0d full, %0d released, %0d out of range.",
               sb.granted_count, sb.full_count, sb.released_count, sb.range_count);
      if (sb.mismatches == 0 && sb.owed_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog: 50 ms is many times the slowest legal run.
   initial begin : watchdog
      #(50_000_000);
      $display("Timeout with %0d results still owed.", sb.owed_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
